// ----- rtl/core/rope_pkg.sv -----
// ----------------------------------------------------------------------------
// Rotary position embedding package
// Shared widths, register indexes, defaults and the result tag type.
// ----------------------------------------------------------------------------
package rope_pkg;

  // Default sizing handed to the top level parameters.
  localparam int MAX_DIM_DEF    = 128;
  localparam int DATA_WIDTH_DEF = 16;

  // Fixed widths of the configuration port and the result index.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int IDX_W      = 7;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROTARY_DIM  = 2'd0,
    REG_INTERLEAVED = 2'd1
  } cfg_reg_t;

  // Tag that travels with a rotated pair through the pipeline.
  typedef struct packed {
    logic [IDX_W-1:0] lo_index;
    logic [IDX_W-1:0] hi_index;
    logic             row_end;
  } pair_tag_t;

endpackage

// ----- rtl/core/rope_seq.sv -----
// ----------------------------------------------------------------------------
// Rotary position embedding sequencer
// Holds the configuration, counts the element position within a row and
// keeps the lower element of each pair in a small memory. Upper elements
// leave this stage together with their buffered lower partner.
// ----------------------------------------------------------------------------
module rope_seq #(
  parameter int MAX_DIM    = 128,
  parameter int DATA_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [DATA_WIDTH-1:0]      in_element_value,
  input  logic signed [DATA_WIDTH-1:0]      in_sine_value,
  input  logic signed [DATA_WIDTH-1:0]      in_cosine_value,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rope_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [rope_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Pipeline advance and stage output
  input  logic                              adv,
  output logic                              s1_valid,
  output logic signed [DATA_WIDTH-1:0]      s1_upper,
  output logic signed [DATA_WIDTH-1:0]      s1_lower,
  output logic signed [DATA_WIDTH-1:0]      s1_sine,
  output logic signed [DATA_WIDTH-1:0]      s1_cosine,
  output rope_pkg::pair_tag_t               s1_tag
);
  import rope_pkg::*;

  localparam int HALF_MAX = MAX_DIM / 2;
  localparam int PW       = $clog2(MAX_DIM);
  localparam int DIM_W    = PW + 1;
  localparam int CMP_W    = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
  localparam int SW       = (HALF_MAX > 1) ? $clog2(HALF_MAX) : 1;

  logic [CFG_DATA_W-1:0]        rotary_dim_r;
  logic                         interleaved_r;
  logic [PW-1:0]                position_r;
  logic [PW-1:0]                position_nxt;

  logic                         s1_valid_r;
  logic signed [DATA_WIDTH-1:0] upper_r;
  logic signed [DATA_WIDTH-1:0] lower_r;
  logic signed [DATA_WIDTH-1:0] sine_r;
  logic signed [DATA_WIDTH-1:0] cosine_r;
  pair_tag_t                    tag_r;

  logic [DATA_WIDTH-1:0]        pair_mem [HALF_MAX];

  logic [CMP_W-1:0]             dim_c;
  logic [CMP_W-1:0]             dim_cap;
  logic [DIM_W-1:0]             dim;
  logic [DIM_W-1:0]             half;
  logic [DIM_W-1:0]             pos_ext;
  logic [DIM_W-1:0]             pos_inc;
  logic [PW-1:0]                pos;
  logic [PW-1:0]                slot_w;
  logic [PW-1:0]                lo_pos;
  logic [SW-1:0]                slot;
  logic                         is_upper;
  logic                         row_last;
  logic [PW+IDX_W-1:0]          pos_wide;
  logic [PW+IDX_W-1:0]          lo_wide;
  logic                         acc;
  logic                         cfg_wr;

  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && adv;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Effective row length: even, at least two, at most MAX_DIM rounded down to even.
  always_comb begin
    dim_cap = CMP_W'(MAX_DIM) & ~CMP_W'(1);
    dim_c   = CMP_W'({rotary_dim_r[CFG_DATA_W-1:1], 1'b0});
    if (dim_c < CMP_W'(2)) begin
      dim_c = CMP_W'(2);
    end
    if (dim_c > dim_cap) begin
      dim_c = dim_cap;
    end
    dim  = DIM_W'(dim_c);
    half = dim >> 1;
  end

  // Pair role, buffer slot and partner index for the current position.
  always_comb begin
    pos_ext = DIM_W'(position_r);
    if (pos_ext >= dim) begin
      pos_ext = '0;
    end
    pos = pos_ext[PW-1:0];
    if (interleaved_r) begin
      is_upper = pos[0];
      slot_w   = pos >> 1;
      lo_pos   = pos - PW'(1);
    end else begin
      is_upper = (pos_ext >= half);
      slot_w   = is_upper ? PW'(pos_ext - half) : pos;
      lo_pos   = slot_w;
    end
    slot     = slot_w[SW-1:0];
    pos_inc  = pos_ext + DIM_W'(1);
    row_last = (pos_inc == dim);
    position_nxt = row_last ? '0 : pos_inc[PW-1:0];
    pos_wide = {{IDX_W{1'b0}}, pos};
    lo_wide  = {{IDX_W{1'b0}}, lo_pos};
  end

  // Configuration registers and row position; any register write restarts the row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotary_dim_r  <= CFG_DATA_W'(64);
      interleaved_r <= 1'b0;
      position_r    <= '0;
      s1_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_reg_t'(cfg_index))
          REG_ROTARY_DIM: begin
            rotary_dim_r <= cfg_data;
            position_r   <= '0;
          end
          REG_INTERLEAVED: begin
            interleaved_r <= cfg_data[0];
            position_r    <= '0;
          end
          default: begin
          end
        endcase
      end else if (acc) begin
        position_r <= position_nxt;
      end
      if (adv) begin
        s1_valid_r <= acc && is_upper;
      end
    end
  end

  // Pair memory: a lower element is written, an upper element reads its partner.
  always_ff @(posedge clk) begin
    if (acc) begin
      if (!is_upper) begin
        pair_mem[slot] <= in_element_value;
      end else begin
        lower_r <= pair_mem[slot];
      end
    end
  end

  // Upper element payload and result tag.
  always_ff @(posedge clk) begin
    if (acc) begin
      upper_r          <= in_element_value;
      sine_r           <= in_sine_value;
      cosine_r         <= in_cosine_value;
      tag_r.lo_index   <= lo_wide[IDX_W-1:0];
      tag_r.hi_index   <= pos_wide[IDX_W-1:0];
      tag_r.row_end    <= row_last;
    end
  end

  assign s1_valid  = s1_valid_r;
  assign s1_upper  = upper_r;
  assign s1_lower  = lower_r;
  assign s1_sine   = sine_r;
  assign s1_cosine = cosine_r;
  assign s1_tag    = tag_r;

endmodule

// ----- rtl/core/rope_mul.sv -----
// ----------------------------------------------------------------------------
// Rotary position embedding product stage
// Forms the four exact products of a pair with its sine and cosine and
// registers them.
// ----------------------------------------------------------------------------
module rope_mul #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              s1_valid,
  input  logic signed [DATA_WIDTH-1:0]      s1_upper,
  input  logic signed [DATA_WIDTH-1:0]      s1_lower,
  input  logic signed [DATA_WIDTH-1:0]      s1_sine,
  input  logic signed [DATA_WIDTH-1:0]      s1_cosine,
  input  rope_pkg::pair_tag_t               s1_tag,
  output logic                              s2_valid,
  output logic signed [2*DATA_WIDTH-1:0]    s2_lc,
  output logic signed [2*DATA_WIDTH-1:0]    s2_us,
  output logic signed [2*DATA_WIDTH-1:0]    s2_uc,
  output logic signed [2*DATA_WIDTH-1:0]    s2_ls,
  output rope_pkg::pair_tag_t               s2_tag
);
  import rope_pkg::*;

  localparam int PROD_W = 2 * DATA_WIDTH;

  logic                     s2_valid_r;
  logic signed [PROD_W-1:0] lc_r;
  logic signed [PROD_W-1:0] us_r;
  logic signed [PROD_W-1:0] uc_r;
  logic signed [PROD_W-1:0] ls_r;
  pair_tag_t                tag_r;

  // Stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid;
    end
  end

  // Four parallel products.
  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      lc_r  <= PROD_W'(s1_lower) * PROD_W'(s1_cosine);
      us_r  <= PROD_W'(s1_upper) * PROD_W'(s1_sine);
      uc_r  <= PROD_W'(s1_upper) * PROD_W'(s1_cosine);
      ls_r  <= PROD_W'(s1_lower) * PROD_W'(s1_sine);
      tag_r <= s1_tag;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_lc    = lc_r;
  assign s2_us    = us_r;
  assign s2_uc    = uc_r;
  assign s2_ls    = ls_r;
  assign s2_tag   = tag_r;

endmodule

// ----- rtl/core/rope_out.sv -----
// ----------------------------------------------------------------------------
// Rotary position embedding output stage
// Sums the products, rounds half up and saturates, then hands out the two
// rotated elements of a pair one transaction at a time.
// ----------------------------------------------------------------------------
module rope_out #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s2_valid,
  input  logic signed [2*DATA_WIDTH-1:0]    s2_lc,
  input  logic signed [2*DATA_WIDTH-1:0]    s2_us,
  input  logic signed [2*DATA_WIDTH-1:0]    s2_uc,
  input  logic signed [2*DATA_WIDTH-1:0]    s2_ls,
  input  rope_pkg::pair_tag_t               s2_tag,
  output logic                              free,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rope_pkg::IDX_W-1:0]        out_index,
  output logic signed [DATA_WIDTH-1:0]      out_value,
  output logic                              out_last_of_item,
  output logic                              out_row_end
);
  import rope_pkg::*;

  localparam int SUM_W = 2 * DATA_WIDTH + 1;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (DATA_WIDTH - 2);

  logic                         valid_r;
  logic                         second_r;
  logic signed [DATA_WIDTH-1:0] r0_r;
  logic signed [DATA_WIDTH-1:0] r1_r;
  pair_tag_t                    tag_r;

  logic signed [SUM_W-1:0]      sum0;
  logic signed [SUM_W-1:0]      sum1;
  logic signed [DATA_WIDTH-1:0] r0;
  logic signed [DATA_WIDTH-1:0] r1;
  logic                         load;

  // Round half up, drop the fraction bits and clamp to the data range.
  function automatic logic signed [DATA_WIDTH-1:0] round_sat(
    input logic signed [SUM_W-1:0] s
  );
    logic signed [SUM_W-1:0] q;
    q = (s + RND) >>> (DATA_WIDTH - 1);
    if (q[SUM_W-1:DATA_WIDTH-1] == {(SUM_W-DATA_WIDTH+1){q[DATA_WIDTH-1]}}) begin
      round_sat = q[DATA_WIDTH-1:0];
    end else if (q[SUM_W-1]) begin
      round_sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      round_sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
  endfunction

  // Rotation sums: lower' = l*c - u*s, upper' = u*c + l*s.
  always_comb begin
    sum0 = SUM_W'(s2_lc) - SUM_W'(s2_us);
    sum1 = SUM_W'(s2_uc) + SUM_W'(s2_ls);
    r0   = round_sat(sum0);
    r1   = round_sat(sum1);
  end

  // The pair register takes a new pair when empty or when its last result leaves.
  assign free = !valid_r || (second_r && out_ready);
  assign load = s2_valid && free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else if (load) begin
      valid_r  <= 1'b1;
      second_r <= 1'b0;
    end else if (valid_r && out_ready) begin
      if (second_r) begin
        valid_r  <= 1'b0;
        second_r <= 1'b0;
      end else begin
        second_r <= 1'b1;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      r0_r  <= r0;
      r1_r  <= r1;
      tag_r <= s2_tag;
    end
  end

  assign out_valid        = valid_r;
  assign out_index        = second_r ? tag_r.hi_index : tag_r.lo_index;
  assign out_value        = second_r ? r1_r : r0_r;
  assign out_last_of_item = second_r;
  assign out_row_end      = tag_r.row_end;

endmodule

// ----- rtl/core/rotary_position_embedding_core.sv -----
// ----------------------------------------------------------------------------
// Rotary position embedding core
// Streams row elements in, rotates each element pair by its sine and cosine
// and streams the rotated elements out with their row positions.
// ----------------------------------------------------------------------------
// The core accepts one element per clock cycle unless stalled. An element
// that opens a pair is kept in the pair memory and gives no result; one that
// closes a pair reads its partner back and, via the sequencer, product and
// output pair registers, yields two results, lower first, on the single
// output port. That port moves one result per cycle while out_ready is high,
// so interleaved rows run at one element per cycle, while in half mode the
// second half of a row is held back. The pair memory sees one write or read
// per accepted element. Any register write restarts the row at position zero.
module rotary_position_embedding_core #(
  parameter int MAX_DIM    = rope_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = rope_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [DATA_WIDTH-1:0]      in_element_value,
  input  logic signed [DATA_WIDTH-1:0]      in_sine_value,
  input  logic signed [DATA_WIDTH-1:0]      in_cosine_value,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rope_pkg::IDX_W-1:0]        out_index,
  output logic signed [DATA_WIDTH-1:0]      out_value,
  output logic                              out_last_of_item,
  output logic                              out_row_end,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rope_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [rope_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rope_pkg::*;

  logic                           adv;
  logic                           free;
  logic                           s1_valid;
  logic signed [DATA_WIDTH-1:0]   s1_upper;
  logic signed [DATA_WIDTH-1:0]   s1_lower;
  logic signed [DATA_WIDTH-1:0]   s1_sine;
  logic signed [DATA_WIDTH-1:0]   s1_cosine;
  pair_tag_t                      s1_tag;
  logic                           s2_valid;
  logic signed [2*DATA_WIDTH-1:0] s2_lc;
  logic signed [2*DATA_WIDTH-1:0] s2_us;
  logic signed [2*DATA_WIDTH-1:0] s2_uc;
  logic signed [2*DATA_WIDTH-1:0] s2_ls;
  pair_tag_t                      s2_tag;

  // The pipeline moves unless a finished pair waits for the output register.
  assign adv = !s2_valid || free;

  rope_seq #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .in_sine_value    (in_sine_value),
    .in_cosine_value  (in_cosine_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .adv              (adv),
    .s1_valid         (s1_valid),
    .s1_upper         (s1_upper),
    .s1_lower         (s1_lower),
    .s1_sine          (s1_sine),
    .s1_cosine        (s1_cosine),
    .s1_tag           (s1_tag)
  );

  rope_mul #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1_upper  (s1_upper),
    .s1_lower  (s1_lower),
    .s1_sine   (s1_sine),
    .s1_cosine (s1_cosine),
    .s1_tag    (s1_tag),
    .s2_valid  (s2_valid),
    .s2_lc     (s2_lc),
    .s2_us     (s2_us),
    .s2_uc     (s2_uc),
    .s2_ls     (s2_ls),
    .s2_tag    (s2_tag)
  );

  rope_out #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .s2_valid         (s2_valid),
    .s2_lc            (s2_lc),
    .s2_us            (s2_us),
    .s2_uc            (s2_uc),
    .s2_ls            (s2_ls),
    .s2_tag           (s2_tag),
    .free             (free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_index        (out_index),
    .out_value        (out_value),
    .out_last_of_item (out_last_of_item),
    .out_row_end      (out_row_end)
  );

endmodule

// ----- dv/rope_rotation_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotary embedding result checker
// Watches the configuration, element and result channels of the core. It
// keeps its own copy of the row position, the held lower elements and the
// register settings. From these it works out the rotated pair for every
// accepted upper element and checks each result field against that pair,
// oldest first.
// ----------------------------------------------------------------------------
module rope_rotation_checker #(
  parameter int MAX_DIM    = rope_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = rope_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [DATA_WIDTH-1:0]      in_element_value,
  input  logic signed [DATA_WIDTH-1:0]      in_sine_value,
  input  logic signed [DATA_WIDTH-1:0]      in_cosine_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [rope_pkg::IDX_W-1:0]        out_index,
  input  logic signed [DATA_WIDTH-1:0]      out_value,
  input  logic                              out_last_of_item,
  input  logic                              out_row_end,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [rope_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [rope_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                fail_count,
  output int                                outstanding
);
  import rope_pkg::*;

  localparam int     FRAC_W      = DATA_WIDTH - 1;
  localparam longint ROUND_BIAS  = longint'(1) << (DATA_WIDTH - 2);
  localparam longint SAT_HI      = (longint'(1) << FRAC_W) - 1;
  localparam longint SAT_LO      = -(longint'(1) << FRAC_W);

  // One rotated element as it should leave the core.
  typedef struct packed {
    logic [IDX_W-1:0]             index;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;
    logic                         row_end;
  } rotated_elem_t;

  // Shadow copy of the core's registers and row state.
  logic [CFG_DATA_W-1:0]        row_dim_reg;
  logic                         pair_adjacent;
  int                           row_pos;
  logic signed [DATA_WIDTH-1:0] held_lower [MAX_DIM/2];

  rotated_elem_t pending_rotations [$];

  // Prints one line for each mismatch and counts it.
  task automatic flag_mismatch(input string what);
    $display("%0t ns rotation mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Round half up, drop the fraction bits and clamp to the sample range.
  function automatic logic signed [DATA_WIDTH-1:0] round_to_sample(input longint acc);
    longint q;
    q = (acc + ROUND_BIAS) >>> FRAC_W;
    if (q > SAT_HI)
      q = SAT_HI;
    else if (q < SAT_LO)
      q = SAT_LO;
    return q[DATA_WIDTH-1:0];
  endfunction

  // Advances the row by one element and queues the rotated pair when the
  // element closes a pair.
  task automatic rotate_element(input logic signed [DATA_WIDTH-1:0] elem,
                                input logic signed [DATA_WIDTH-1:0] sn,
                                input logic signed [DATA_WIDTH-1:0] cs);
    int            dim;
    int            half;
    int            pos;
    int            slot;
    int            lo_idx;
    bit            is_upper;
    longint        lower;
    longint        x;
    longint        s;
    longint        c;
    rotated_elem_t r;
    dim = int'(row_dim_reg & 8'hFE);
    if (dim < 2)
      dim = 2;
    if (dim > MAX_DIM)
      dim = MAX_DIM & ~1;
    half = dim / 2;
    pos  = (row_pos >= dim) ? 0 : row_pos;
    if (pair_adjacent) begin
      is_upper = (pos % 2) == 1;
      slot     = pos / 2;
      lo_idx   = pos - 1;
    end else begin
      is_upper = pos >= half;
      slot     = is_upper ? pos - half : pos;
      lo_idx   = slot;
    end
    if (slot >= MAX_DIM / 2)
      slot = MAX_DIM / 2 - 1;
    row_pos = (pos + 1 >= dim) ? 0 : pos + 1;

    // A lower element is only held; its sine and cosine play no part.
    if (!is_upper) begin
      held_lower[slot] = elem;
      return;
    end

    lower = longint'(held_lower[slot]);
    x     = longint'(elem);
    s     = longint'(sn);
    c     = longint'(cs);
    r.row_end = (pos + 1 == dim);
    r.index   = lo_idx[IDX_W-1:0];
    r.value   = round_to_sample(lower * c - x * s);
    r.last    = 1'b0;
    pending_rotations.push_back(r);
    r.index   = pos[IDX_W-1:0];
    r.value   = round_to_sample(x * c + lower * s);
    r.last    = 1'b1;
    pending_rotations.push_back(r);
  endtask

  // All three channels are sampled at the rising edge.
  always @(posedge clk) begin
    rotated_elem_t want;
    if (!rst_n) begin
      row_dim_reg   = 8'd64;
      pair_adjacent = 1'b0;
      row_pos       = 0;
      fail_count    = 0;
      pending_rotations.delete();
      outstanding <= 0;
    end else begin
      // A register write restarts the row; held elements are kept.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROTARY_DIM: begin
            row_dim_reg = cfg_data;
            row_pos     = 0;
          end
          REG_INTERLEAVED: begin
            pair_adjacent = cfg_data[0];
            row_pos       = 0;
          end
          default: ;
        endcase
      end

      if (in_valid && in_ready)
        rotate_element(in_element_value, in_sine_value, in_cosine_value);

      // Each result transaction is checked against the oldest expectation.
      if (out_valid && out_ready) begin
        if (pending_rotations.size() == 0) begin
          flag_mismatch($sformatf("result index %0d value %0d with nothing expected",
                                  out_index, out_value));
        end else begin
          want = pending_rotations.pop_front();
          if (out_index !== want.index)
            flag_mismatch($sformatf("index got %0d want %0d", out_index, want.index));
          if (out_value !== want.value)
            flag_mismatch($sformatf("value at index %0d got %0d want %0d",
                                    want.index, out_value, want.value));
          if (out_last_of_item !== want.last)
            flag_mismatch($sformatf("last_of_item at index %0d got %b want %b",
                                    want.index, out_last_of_item, want.last));
          if (out_row_end !== want.row_end)
            flag_mismatch($sformatf("row_end at index %0d got %b want %b",
                                    want.index, out_row_end, want.row_end));
        end
      end
      outstanding <= pending_rotations.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotary embedding core testbench
// Streams row elements with their sine and cosine through the core under a
// series of row lengths and pairing modes, starting with corner values on
// single-pair rows and going on to random rows, partial rows and idle gaps on
// both channels. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import rope_pkg::*;

  localparam int DW          = DATA_WIDTH_DEF;
  localparam int TOTAL_ITEMS = 1750;
  localparam int CALM_ITEMS  = 300;
  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 500000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [DW-1:0]  in_element_value;
  logic signed [DW-1:0]  in_sine_value;
  logic signed [DW-1:0]  in_cosine_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [IDX_W-1:0]      out_index;
  logic signed [DW-1:0]  out_value;
  logic                  out_last_of_item;
  logic                  out_row_end;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   fail_count;
  int   outstanding;
  int   sent_count;
  int   cycle_count;
  int   hold_serial;
  bit   idle_enable;
  logic [CFG_DATA_W-1:0] cur_dim;

  rotary_position_embedding_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .in_sine_value    (in_sine_value),
    .in_cosine_value  (in_cosine_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_index        (out_index),
    .out_value        (out_value),
    .out_last_of_item (out_last_of_item),
    .out_row_end      (out_row_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  rope_rotation_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .in_sine_value    (in_sine_value),
    .in_cosine_value  (in_cosine_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_index        (out_index),
    .out_value        (out_value),
    .out_last_of_item (out_last_of_item),
    .out_row_end      (out_row_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit: the run is called failed if it has not finished by then.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[rotary_position_embedding_core] ERROR");
    $finish;
  end

  // Result side: random stall bursts, plus a long hold-off each time one is requested.
  initial begin
    int stall_left;
    int hold_seen;
    stall_left = 0;
    hold_seen  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_serial != hold_seen) begin
        hold_seen  = hold_serial;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_enable && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Mostly full-range samples, with the corner values mixed in often.
  function automatic logic signed [DW-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(DW-1){1'b0}}};
      1:       return {1'b0, {(DW-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return r[DW-1:0];
    endcase
  endfunction

  // Elements per row for a given rotary_dim register value.
  function automatic int row_length(input logic [CFG_DATA_W-1:0] reg_val);
    int d;
    d = int'(reg_val & 8'hFE);
    if (d < 2)
      d = 2;
    if (d > MAX_DIM_DEF)
      d = MAX_DIM_DEF;
    return d;
  endfunction

  // Offers one element and returns once its transaction has happened.
  task automatic push_element(input logic signed [DW-1:0] elem,
                              input logic signed [DW-1:0] sn,
                              input logic signed [DW-1:0] cs);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_element_value <= elem;
    in_sine_value    <= sn;
    in_cosine_value  <= cs;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // Stops offering elements and waits until every result has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Register write, issued only once the core has gone quiet.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Writes both registers in random order; upper mode bits are random.
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] dim_val, input logic adjacent);
    logic [CFG_DATA_W-1:0] mode_val;
    mode_val    = CFG_DATA_W'($urandom());
    mode_val[0] = adjacent;
    cur_dim     = dim_val;
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_ROTARY_DIM, dim_val);
      write_reg(REG_INTERLEAVED, mode_val);
    end else begin
      write_reg(REG_INTERLEAVED, mode_val);
      write_reg(REG_ROTARY_DIM, dim_val);
    end
  endtask

  task automatic send_elements(input int count);
    repeat (count) push_element(pick_sample(), pick_sample(), pick_sample());
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] dim_val;
    int len;
    int phase;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_element_value <= '0;
    in_sine_value    <= '0;
    in_cosine_value  <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= REG_ROTARY_DIM;
    cfg_data         <= '0;
    hold_serial      = 0;
    idle_enable      = 1'b0;
    sent_count       = 0;
    cur_dim          = 8'd64;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-pair rows with corner values. Each pair is lower then upper;
    // the sine and cosine given with the lower element must be ignored.
    write_reg(REG_ROTARY_DIM, 8'd2);
    push_element(16'sh8000, 16'sh1234, 16'sh4321);
    push_element(16'sh8000, 16'sh8000, 16'sh8000);    // sum overflows upward
    push_element(16'sh7FFF, 16'sh8000, 16'sh8000);
    push_element(16'sh8000, 16'sh7FFF, 16'sh7FFF);
    push_element(16'sh8000, 16'sh0000, 16'sh0000);
    push_element(16'sh7FFF, 16'sh7FFF, 16'sh8000);    // saturates downward
    push_element(16'sh0001, 16'sh0000, 16'sh0000);
    push_element(16'sh0000, 16'sh0000, 16'sh4000);    // exact half rounds up
    push_element(16'shFFFF, 16'sh0000, 16'sh0000);
    push_element(16'sh0000, 16'sh0000, 16'sh4000);    // negative half rounds to zero
    push_element(16'sh0001, 16'sh0000, 16'sh0000);
    push_element(16'sh0000, 16'sh0000, 16'sh3FFF);    // just below half
    push_element(16'sh0000, 16'shFFFF, 16'shFFFF);
    push_element(16'sh0000, 16'sh7FFF, 16'sh0000);

    // Register values below the minimum and with the low bit set.
    write_reg(REG_INTERLEAVED, 8'hFF);
    write_reg(REG_ROTARY_DIM, 8'd0);
    send_elements(2);
    write_reg(REG_ROTARY_DIM, 8'd5);
    send_elements(4);
    write_reg(REG_INTERLEAVED, 8'h00);
    send_elements(4);

    // Random phases: a setting, then mostly whole rows, sometimes a broken one.
    phase = 0;
    while (sent_count < TOTAL_ITEMS) begin
      idle_enable = (sent_count < TOTAL_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        // Long result hold-off while the sender keeps offering full rows.
        apply_setting(8'd128, 1'b0);
        idle_enable = 1'b0;
        hold_serial++;
        send_elements(256);
      end else if (phase == 5) begin
        // Sender pauses mid-row until every result is out, then finishes the row.
        apply_setting(8'd24, 1'b0);
        send_elements(17);
        wait_for_results();
        send_elements(7);
      end else begin
        case ($urandom_range(0, 9))
          0:       dim_val = 8'd0;
          1:       dim_val = 8'd1;
          2:       dim_val = 8'd255;
          3:       dim_val = 8'd128;
          4:       dim_val = CFG_DATA_W'($urandom_range(129, 254));
          5:       dim_val = CFG_DATA_W'($urandom_range(18, 127));
          default: dim_val = CFG_DATA_W'($urandom_range(2, 17));
        endcase
        apply_setting(dim_val, 1'($urandom_range(0, 1)));
        len = row_length(cur_dim);
        repeat ((len > 64) ? 1 : $urandom_range(1, 4)) send_elements(len);
        if ($urandom_range(0, 4) == 0)
          send_elements((len > 2) ? $urandom_range(1, len - 1) : 1);
      end
      phase++;
    end

    // Drain, then allow the pipeline a few more cycles to show stray results.
    idle_enable = 1'b0;
    wait_for_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("[rotary_position_embedding_core] OK");
    else
      $display("[rotary_position_embedding_core] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rope_pkg.sv
rtl/core/rope_seq.sv
rtl/core/rope_mul.sv
rtl/core/rope_out.sv
rtl/core/rotary_position_embedding_core.sv
dv/rope_rotation_checker.sv
dv/tb.sv
